>>> hw/rtl/shuffled_order_cursor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shuffled order cursor unit
// Short forms of the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_ORDER_CURSOR_UNIT_MACROS_SVH
`define SHUFFLED_ORDER_CURSOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SOU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds while reset is applied.
`define SOU_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sou_pkg.sv
// ----------------------------------------------------------------------------
// sou_pkg
// Shared types, codes and helpers of the shuffled order cursor unit.
// ----------------------------------------------------------------------------
package sou_pkg;

  localparam int unsigned RND_W     = 32;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned ENTRY_W   = 8;
  localparam int unsigned IN_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_SHUFFLE = 2'd0,
    OP_SYNC    = 2'd1,
    OP_NEXT    = 2'd2,
    OP_PREV    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RD_CUR = 2'd0,
    RD_IDX = 2'd1,
    RD_J   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    in_load;
    logic    len_load;
    logic    cur_clear;
    logic    cur_inc;
    logic    cur_dec;
    logic    cur_last;
    logic    cur_from_idx;
    logic    idx_clear;
    logic    idx_inc;
    logic    idx_dec;
    logic    fill_wr;
    logic    mod_start;
    logic    tmp_load;
    logic    wr_i;
    logic    wr_j;
    rd_sel_t rd_sel;
    logic    out_load;
    logic    out_valid;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic wrap;
    logic count_zero;
    logic len_zero;
    logic cur_at_end;
    logic cur_zero;
    logic idx_zero;
    logic idx_one;
    logic idx_last;
    logic scan_hit;
    logic mod_busy;
    logic out_free;
  } sts_t;

  function automatic logic [RND_W-1:0] xorshift32(input logic [RND_W-1:0] x);
    logic [RND_W-1:0] a;
    logic [RND_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

>>> hw/rtl/shuffled_order_cursor_unit.sv
// ----------------------------------------------------------------------------
// shuffled_order_cursor_unit
// Next and previous step the cursor and return the entry there, or answer
// invalid; sync looks for the search value in the table and moves the
// cursor to it; a reshuffle of n entries fills the table and makes n-1
// swaps, each drawing its index with the 32-step remainder unit.
// One operation is worked on at a time; the next is taken once its result
// sits in the output register. Synchronous reset empties the order, clears
// the cursor and loads the generator with 1; the table itself is not cleared.
// ----------------------------------------------------------------------------
module shuffled_order_cursor_unit #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [8:0] item_count, [16:9] search_value, [17] wrap_enable, [23:18] zero
  input  logic [sou_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] entry
  output logic [sou_pkg::ENTRY_W-1:0]     m_axis_tdata,
  // [0] entry_valid
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sou_pkg::RND_W-1:0]       cfg_data
);

  sou_pkg::cmd_t cmd;
  sou_pkg::sts_t sts;
  logic          in_ready;

  assign s_axis_tready = in_ready;
  assign cfg_ready     = in_ready;

  sou_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sou_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (sou_pkg::op_t'(s_axis_tuser)),
    .in_count        (s_axis_tdata[8:0]),
    .in_value        (s_axis_tdata[16:9]),
    .in_wrap         (s_axis_tdata[17]),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_seed        (cfg_data),
    .out_tvalid      (m_axis_tvalid),
    .out_tready      (m_axis_tready),
    .out_entry       (m_axis_tdata),
    .out_entry_valid (m_axis_tuser)
  );

endmodule

>>> hw/rtl/sou_mod_unit.sv
// ----------------------------------------------------------------------------
// sou_mod_unit
// Restoring remainder unit: 32-bit dividend modulo a small divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sou_mod_unit #(
  parameter int unsigned DIV_W = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sou_pkg::RND_W-1:0]   dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        busy,
  output logic [DIV_W-1:0]            remainder
);

  localparam int unsigned CNT_W = $clog2(sou_pkg::RND_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic [sou_pkg::RND_W-1:0] dvd;
  logic [DIV_W-1:0]          dvs;
  logic [DIV_W:0]            trial;
  logic [DIV_W:0]            diff;
  logic                      take;

  assign trial = {remainder, dvd[sou_pkg::RND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(sou_pkg::RND_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one subtract restores it.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

endmodule

>>> hw/rtl/sou_dp.sv
// ----------------------------------------------------------------------------
// sou_dp
// Datapath: order table, cursor, length, random generator, swap and scan
// registers, and the result register.
// ----------------------------------------------------------------------------
module sou_dp #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sou_pkg::cmd_t                  cmd,
  output sou_pkg::sts_t                  sts,
  input  sou_pkg::op_t                   in_op,
  input  logic [sou_pkg::COUNT_W-1:0]    in_count,
  input  logic [sou_pkg::VALUE_W-1:0]    in_value,
  input  logic                           in_wrap,
  input  logic                           cfg_write,
  input  logic [sou_pkg::RND_W-1:0]      cfg_seed,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sou_pkg::ENTRY_W-1:0]    out_entry,
  output logic                           out_entry_valid
);

  localparam int unsigned IW   = $clog2(MAX_ENTRIES);
  localparam int unsigned LW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW   = (IW > sou_pkg::VALUE_W) ? IW : sou_pkg::VALUE_W;
  localparam int unsigned CMPW = (LW > sou_pkg::COUNT_W) ? LW : sou_pkg::COUNT_W;

  logic [IW-1:0]               mem [MAX_ENTRIES];
  logic [IW-1:0]               rd_data;
  logic [IW-1:0]               rd_addr;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [IW-1:0]               wr_data;

  sou_pkg::op_t                op;
  logic [sou_pkg::COUNT_W-1:0] count;
  logic [sou_pkg::VALUE_W-1:0] value;
  logic                        wrap;
  logic [LW-1:0]               len;
  logic [IW-1:0]               cur;
  logic [IW-1:0]               idx;
  logic [IW-1:0]               tmp;
  logic [sou_pkg::RND_W-1:0]   rnd;
  logic [sou_pkg::RND_W-1:0]   rnd_next;
  logic [LW-1:0]               count_sat;
  logic [LW-1:0]               len_m1;
  logic [LW-1:0]               divisor;
  logic [LW-1:0]               remainder;
  logic [IW-1:0]               j_idx;
  logic                        mod_busy;

  assign rnd_next  = sou_pkg::xorshift32(rnd);
  assign count_sat = (CMPW'(count) > CMPW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(count);
  assign len_m1    = len - LW'(1);
  assign divisor   = LW'(idx) + LW'(1);
  assign j_idx     = IW'(remainder);

  sou_mod_unit #(
    .DIV_W (LW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (rnd_next),
    .divisor   (divisor),
    .busy      (mod_busy),
    .remainder (remainder)
  );

  // Latched operation.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op    <= in_op;
      count <= in_count;
      value <= in_value;
      wrap  <= in_wrap;
    end
  end

  // Generator state: a seed write reloads it, each swap draws one value.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= sou_pkg::RND_W'(1);
    end else if (cfg_write) begin
      rnd <= (cfg_seed == '0) ? sou_pkg::RND_W'(1) : cfg_seed;
    end else if (cmd.mod_start) begin
      rnd <= rnd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      cur <= '0;
    end else begin
      if (cmd.len_load) begin
        len <= count_sat;
      end
      if (cmd.cur_clear) begin
        cur <= '0;
      end else if (cmd.cur_inc) begin
        cur <= cur + IW'(1);
      end else if (cmd.cur_dec) begin
        cur <= cur - IW'(1);
      end else if (cmd.cur_last) begin
        cur <= IW'(len_m1);
      end else if (cmd.cur_from_idx) begin
        cur <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - IW'(1);
    end
    if (cmd.tmp_load) begin
      tmp <= rd_data;
    end
  end

  // Table ports: one write, one registered read.
  always_comb begin
    case (cmd.rd_sel)
      sou_pkg::RD_IDX: rd_addr = idx;
      sou_pkg::RD_J:   rd_addr = j_idx;
      default:         rd_addr = cur;
    endcase
    wr_en   = cmd.fill_wr | cmd.wr_i | cmd.wr_j;
    wr_addr = cmd.wr_j ? j_idx : idx;
    if (cmd.fill_wr) begin
      wr_data = idx;
    end else if (cmd.wr_i) begin
      wr_data = rd_data;
    end else begin
      wr_data = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry       <= cmd.out_valid ? sou_pkg::ENTRY_W'(rd_data) : '0;
      out_entry_valid <= cmd.out_valid;
    end
  end

  always_comb begin
    sts.op         = op;
    sts.wrap       = wrap;
    sts.count_zero = (count == '0);
    sts.len_zero   = (len == '0);
    sts.cur_at_end = ((LW'(cur) + LW'(1)) >= len);
    sts.cur_zero   = (cur == '0);
    sts.idx_zero   = (idx == '0);
    sts.idx_one    = (idx == IW'(1));
    sts.idx_last   = (idx == IW'(len_m1));
    sts.scan_hit   = (CW'(rd_data) == CW'(value));
    sts.mod_busy   = mod_busy;
    sts.out_free   = !out_tvalid || out_tready;
  end

endmodule

>>> hw/rtl/sou_ctrl.sv
// ----------------------------------------------------------------------------
// sou_ctrl
// Controller: sequences decode, table fill, shuffle swaps, value scan,
// cursor read and the result transfer.
// ----------------------------------------------------------------------------
module sou_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sou_pkg::sts_t sts,
  output sou_pkg::cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_DECODE     = 14'b00000000000010,
    S_FILL       = 14'b00000000000100,
    S_MOD_START  = 14'b00000000001000,
    S_MOD_WAIT   = 14'b00000000010000,
    S_SW_RD_I    = 14'b00000000100000,
    S_SW_RD_J    = 14'b00000001000000,
    S_SW_WR_I    = 14'b00000010000000,
    S_SW_WR_J    = 14'b00000100000000,
    S_SCAN_RD    = 14'b00001000000000,
    S_SCAN_CMP   = 14'b00010000000000,
    S_READ       = 14'b00100000000000,
    S_DONE_NONE  = 14'b01000000000000,
    S_DONE_ENTRY = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t shuffle_exit;

  assign in_ready = (state == S_IDLE);

  // A plain reshuffle answers invalid; a wrap on next reports slot zero.
  assign shuffle_exit = (sts.op == sou_pkg::OP_SHUFFLE) ? S_DONE_NONE : S_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = sou_pkg::RD_CUR;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          sou_pkg::OP_SHUFFLE: begin
            cmd.len_load  = 1'b1;
            cmd.cur_clear = 1'b1;
            cmd.idx_clear = 1'b1;
            state_next    = sts.count_zero ? S_DONE_NONE : S_FILL;
          end
          sou_pkg::OP_SYNC: begin
            cmd.idx_clear = 1'b1;
            state_next    = sts.len_zero ? S_DONE_NONE : S_SCAN_RD;
          end
          sou_pkg::OP_NEXT: begin
            if (sts.len_zero) begin
              state_next = S_DONE_NONE;
            end else if (!sts.cur_at_end) begin
              cmd.cur_inc = 1'b1;
              state_next  = S_READ;
            end else if (sts.wrap) begin
              cmd.cur_clear = 1'b1;
              cmd.idx_clear = 1'b1;
              state_next    = S_FILL;
            end else begin
              state_next = S_DONE_NONE;
            end
          end
          sou_pkg::OP_PREV: begin
            if (sts.len_zero) begin
              state_next = S_DONE_NONE;
            end else if (!sts.cur_zero) begin
              cmd.cur_dec = 1'b1;
              state_next  = S_READ;
            end else if (sts.wrap) begin
              cmd.cur_last = 1'b1;
              state_next   = S_READ;
            end else begin
              state_next = S_DONE_NONE;
            end
          end
          default: state_next = S_DONE_NONE;
        endcase
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (!sts.idx_last) begin
          cmd.idx_inc = 1'b1;
        end else if (sts.idx_zero) begin
          state_next = shuffle_exit;
        end else begin
          state_next = S_MOD_START;
        end
      end
      S_MOD_START: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (!sts.mod_busy) begin
          state_next = S_SW_RD_I;
        end
      end
      S_SW_RD_I: begin
        cmd.rd_sel = sou_pkg::RD_IDX;
        state_next = S_SW_RD_J;
      end
      S_SW_RD_J: begin
        cmd.rd_sel   = sou_pkg::RD_J;
        cmd.tmp_load = 1'b1;
        state_next   = S_SW_WR_I;
      end
      S_SW_WR_I: begin
        cmd.wr_i   = 1'b1;
        state_next = S_SW_WR_J;
      end
      S_SW_WR_J: begin
        cmd.wr_j = 1'b1;
        if (sts.idx_one) begin
          state_next = shuffle_exit;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_MOD_START;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_sel = sou_pkg::RD_IDX;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.scan_hit) begin
          cmd.cur_from_idx = 1'b1;
          state_next       = S_DONE_NONE;
        end else if (sts.idx_last) begin
          state_next = S_DONE_NONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_READ: begin
        state_next = S_DONE_ENTRY;
      end
      S_DONE_NONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DONE_ENTRY: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_valid = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/sou_checker.sv
// ----------------------------------------------------------------------------
// sou_checker
// Port-level checks of the shuffled order cursor unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "shuffled_order_cursor_unit_macros.svh"

module sou_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [sou_pkg::ENTRY_W-1:0] m_axis_tdata,
  input logic                        m_axis_tuser,
  input logic                        cfg_ready
);

  // No result may be pending right after reset.
  `SOU_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid, "result valid after reset")

  // A stalled result holds.
  `SOU_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // An invalid answer carries a zero entry.
  `SOU_ASSERT_IMP(a_invalid_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid result with nonzero entry")

  // After an operation transfer neither input is ready in the cycle after it.
  `SOU_ASSERT_NXT(a_busy_after_in, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready && !cfg_ready, "ready right after transfer")

endmodule

bind shuffled_order_cursor_unit sou_checker u_sou_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready     (cfg_ready)
);
